// File: hw/rtl/dlf_pkg.sv
// shared types and constants for the dense layer forward block
// no dependencies; imported by dlf_cell and dense_layer_forward
package dlf_pkg;

   // fixed point formats: Q8.8 data, Q16.16 products, 40 bit accumulators
   localparam int DATA_W = 16;
   localparam int FRAC_W = DATA_W / 2;
   localparam int ACC_W  = 40;

   // request kinds
   typedef enum logic [1:0] {
      KIND_WEIGHT  = 2'd0,
      KIND_BIAS    = 2'd1,
      KIND_ELEMENT = 2'd2
   } kind_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic wr_weight;
      logic wr_bias;
      logic read;
      logic mul;
      logic acc;
      logic finish;
      logic shift;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/dlf_cell.sv
// one node of the layer: weight column memory, bias, multiply-accumulate
// and one stage of the result shift chain; depends on dlf_pkg
module dlf_cell #(
   parameter int MAX_INPUTS = 64,
   parameter int IDX_W      = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlf_pkg::cell_ctrl_type              ctrl,
   input  logic                                sel,
   input  logic [IDX_W-1:0]                    wr_addr,
   input  logic signed [dlf_pkg::DATA_W-1:0]   wr_data,
   input  logic [IDX_W-1:0]                    rd_addr,
   input  logic signed [dlf_pkg::DATA_W-1:0]   x,
   input  logic signed [dlf_pkg::DATA_W-1:0]   shift_in,
   output logic signed [dlf_pkg::DATA_W-1:0]   shift_out
);
   import dlf_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = ACC_W + 2;

   logic signed [DATA_W-1:0] weight_mem [MAX_INPUTS];
   logic signed [DATA_W-1:0] weight_rd_ff;
   logic signed [PROD_W-1:0] product_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DATA_W-1:0] bias_ff;
   logic signed [DATA_W-1:0] out_ff;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  quot;
   logic signed [DATA_W-1:0] result_in;

   // weight column memory, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_weight && sel) begin
         weight_mem[wr_addr] <= wr_data;
      end
      if (ctrl.read) begin
         weight_rd_ff <= weight_mem[rd_addr];
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         product_ff <= x * weight_rd_ff;
      end
   end

   // accumulator and bias
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         bias_ff <= '0;
      end else begin
         if (ctrl.finish) begin
            acc_ff <= '0;
         end else if (ctrl.acc) begin
            acc_ff <= acc_ff + ACC_W'(product_ff);
         end
         if (ctrl.wr_bias && sel) begin
            bias_ff <= wr_data;
         end
      end
   end

   // add bias, round half up, floor shift, saturate to the data range
   always_comb begin
      sum  = SUM_W'(acc_ff) + (SUM_W'(bias_ff) <<< FRAC_W)
             + (SUM_W'(1) << (FRAC_W - 1));
      quot = sum >>> FRAC_W;
      if (quot[SUM_W-1:DATA_W-1] == '0 || quot[SUM_W-1:DATA_W-1] == '1) begin
         result_in = quot[DATA_W-1:0];
      end else begin
         result_in = {quot[SUM_W-1], {(DATA_W-1){~quot[SUM_W-1]}}};
      end
   end

   // result shift stage toward the head of the chain
   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         out_ff <= result_in;
      end else if (ctrl.shift) begin
         out_ff <= shift_in;
      end
   end

   assign shift_out = out_ff;

endmodule

// File: hw/rtl/dense_layer_forward.sv
// top level of the dense layer forward block: sequencer, element position,
// result output register and the chain of dlf_cell nodes; depends on dlf_pkg
//
// Weight, bias and non-final activation transactions are taken one per cycle
// with no stall while busy is low. Each activation element is broadcast to a
// chain of cells, one per node, each doing a weight read, multiply and
// accumulate in a three stage path. A transaction with last_element set holds
// busy high through the flush of that path in last_a, last_b and last_c, the
// finish, and the shift of count results, count being n_outputs clamped to
// 1..MAX_OUTPUTS, out of the head of the cell chain in node order, one result
// per cycle. Results appear on rsp_* for one cycle each, marked by rsp_strobe,
// and cannot be held off. n_outputs may only be written while busy is low.
module dense_layer_forward #(
   parameter int MAX_OUTPUTS = 16,
   parameter int MAX_INPUTS  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [3:0]                         req_node_index,
   input  logic [5:0]                         req_input_index,
   input  logic signed [dlf_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last_element,
   output logic                               rsp_strobe,
   output logic signed [dlf_pkg::DATA_W-1:0]  rsp_node_output,
   output logic [3:0]                         rsp_output_index,
   output logic                               rsp_last_result,
   input  logic                               csr_we,
   input  logic [4:0]                         csr_n_outputs
);
   import dlf_pkg::*;

   localparam int IDX_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int POS_W  = $clog2(MAX_INPUTS + 1);
   localparam int NODE_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);

   logic                      accept;
   logic                      elem_acc;
   logic                      elem_in;
   cell_ctrl_type             ctrl;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          rd_addr;
   logic [CNT_W-1:0]          count;
   logic                      drain_last;

   logic [4:0]                n_outputs_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      busy_ff;
   logic signed [DATA_W-1:0]  x_ff;
   logic                      vld_a_ff;
   logic                      last_a_ff;
   logic                      vld_b_ff;
   logic                      last_b_ff;
   logic                      last_c_ff;
   logic                      drain_ff;
   logic [NODE_W-1:0]         cnt_ff;
   logic                      rsp_strobe_ff;
   logic signed [DATA_W-1:0]  rsp_node_output_ff;
   logic [3:0]                rsp_output_index_ff;
   logic                      rsp_last_result_ff;

   logic signed [DATA_W-1:0]  chain [MAX_OUTPUTS+1];

   // transaction decode
   assign accept   = start && !busy_ff;
   assign elem_in  = accept && (req_kind == KIND_ELEMENT);
   assign elem_acc = elem_in && (32'(pos_ff) < 32'(MAX_INPUTS));
   assign wr_addr  = IDX_W'(req_input_index);
   assign rd_addr  = IDX_W'(pos_ff);

   always_comb begin
      ctrl           = '0;
      ctrl.wr_weight = accept && (req_kind == KIND_WEIGHT)
                       && (32'(req_input_index) < 32'(MAX_INPUTS));
      ctrl.wr_bias   = accept && (req_kind == KIND_BIAS);
      ctrl.read      = elem_acc;
      ctrl.mul       = vld_a_ff;
      ctrl.acc       = vld_b_ff;
      ctrl.finish    = last_c_ff;
      ctrl.shift     = drain_ff;
   end

   // clamped node count
   always_comb begin
      if (n_outputs_ff == '0) begin
         count = CNT_W'(1);
      end else if (32'(n_outputs_ff) > 32'(MAX_OUTPUTS)) begin
         count = CNT_W'(MAX_OUTPUTS);
      end else begin
         count = CNT_W'(n_outputs_ff);
      end
   end

   assign drain_last = (32'(cnt_ff) + 32'd1 == 32'(count));

   // sequencer: position, pipeline flags, drain and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         n_outputs_ff <= 5'd1;
         pos_ff       <= '0;
         busy_ff      <= 1'b0;
         vld_a_ff     <= 1'b0;
         last_a_ff    <= 1'b0;
         vld_b_ff     <= 1'b0;
         last_b_ff    <= 1'b0;
         last_c_ff    <= 1'b0;
         drain_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            n_outputs_ff <= csr_n_outputs;
         end
         if (elem_in) begin
            if (req_last_element) begin
               pos_ff  <= '0;
               busy_ff <= 1'b1;
            end else if (elem_acc) begin
               pos_ff <= pos_ff + POS_W'(1);
            end
         end
         vld_a_ff  <= elem_acc;
         last_a_ff <= elem_in && req_last_element;
         vld_b_ff  <= vld_a_ff;
         last_b_ff <= last_a_ff;
         last_c_ff <= last_b_ff;
         if (last_c_ff) begin
            drain_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (drain_ff) begin
            cnt_ff <= cnt_ff + NODE_W'(1);
            if (drain_last) begin
               drain_ff <= 1'b0;
               busy_ff  <= 1'b0;
            end
         end
      end
   end

   // activation operand for the multiply stage
   always_ff @(posedge clock) begin
      if (elem_acc) begin
         x_ff <= req_value;
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= drain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_ff) begin
         rsp_node_output_ff  <= chain[0];
         rsp_output_index_ff <= 4'(cnt_ff);
         rsp_last_result_ff  <= drain_last;
      end
   end

   // chain of node cells, results shift toward cell zero
   assign chain[MAX_OUTPUTS] = '0;

   for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
      dlf_cell #(
         .MAX_INPUTS (MAX_INPUTS),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sel       (32'(req_node_index) == i),
         .wr_addr   (wr_addr),
         .wr_data   (req_value),
         .rd_addr   (rd_addr),
         .x         (x_ff),
         .shift_in  (chain[i+1]),
         .shift_out (chain[i])
      );
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_node_output  = rsp_node_output_ff;
   assign rsp_output_index = rsp_output_index_ff;
   assign rsp_last_result  = rsp_last_result_ff;

`ifndef SYNTHESIS
   // a result only follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy_ff))
      else $error("result strobe without a preceding busy cycle");

   // the last result of a vector releases busy
   a_last_frees_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_result_ff) |-> !busy_ff)
      else $error("busy still high after the last result");

   // finish happens only inside a busy window
   a_finish_in_busy: assert property (@(posedge clock) disable iff (reset)
      last_c_ff |-> busy_ff)
      else $error("finish outside of busy");

   // results of one vector come back to back in node order
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_result_ff) |=>
         (rsp_strobe_ff && rsp_output_index_ff == 4'($past(rsp_output_index_ff) + 4'd1)))
      else $error("result index did not advance by one");
`endif

endmodule
